### rtl/char_lcd_shadow_refresh_core_macros.svh
// Assertion macros shared by the character LCD refresh RTL.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef CHAR_LCD_SHADOW_REFRESH_CORE_MACROS_SVH
`define CHAR_LCD_SHADOW_REFRESH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LCDSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LCDSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lcdsr_pkg.sv
// Shared types, step codes and constants for the character LCD refresh block.
// Depends on nothing; imported by every module of the block.
package lcdsr_pkg;

  localparam int ROWS = 2;
  localparam int COL_W = 6;
  localparam int PC_W = 4;
  localparam int IC_W = 3;
  localparam int INIT_LEN = 6;

  // Operation codes of an input beat
  localparam logic [2:0] OP_INIT       = 3'd0;
  localparam logic [2:0] OP_CLEAR      = 3'd1;
  localparam logic [2:0] OP_PUT_CHAR   = 3'd2;
  localparam logic [2:0] OP_FLUSH      = 3'd3;
  localparam logic [2:0] OP_FLUSH_FULL = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Microprogram steps
  localparam logic [PC_W-1:0] P_IDLE       = 4'd0;
  localparam logic [PC_W-1:0] P_INIT       = 4'd1;
  localparam logic [PC_W-1:0] P_FILL_ALL   = 4'd2;
  localparam logic [PC_W-1:0] P_FILL_FRAME = 4'd3;
  localparam logic [PC_W-1:0] P_PUT        = 4'd4;
  localparam logic [PC_W-1:0] P_FC_ADDR    = 4'd5;
  localparam logic [PC_W-1:0] P_FC_DATA    = 4'd6;
  localparam logic [PC_W-1:0] P_FF_ADDR    = 4'd7;
  localparam logic [PC_W-1:0] P_FF_DATA    = 4'd8;
  localparam logic [PC_W-1:0] P_FF_ROW     = 4'd9;
  localparam logic [PC_W-1:0] P_DONE       = 4'd10;

  // Emit selects
  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_INIT = 3'd1;
  localparam logic [2:0] E_ADDR = 3'd2;
  localparam logic [2:0] E_DATA = 3'd3;
  localparam logic [2:0] E_DONE = 3'd4;

  // Emit gates
  localparam logic [1:0] G_ALWAYS    = 2'd0;
  localparam logic [1:0] G_DIFF_NEED = 2'd1;
  localparam logic [1:0] G_DIFF      = 2'd2;

  // Jump conditions
  localparam logic [2:0] C_ALWAYS    = 3'd0;
  localparam logic [2:0] C_DISPATCH  = 3'd1;
  localparam logic [2:0] C_IC_LAST   = 3'd2;
  localparam logic [2:0] C_LAST_CELL = 3'd3;
  localparam logic [2:0] C_ROW_END   = 3'd4;
  localparam logic [2:0] C_ROW_ONE   = 3'd5;

  // Bus constants
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] DDRAM_ROW0  = 8'h80;
  localparam logic [7:0] DDRAM_ROW1  = 8'hC0;
  localparam logic [3:0] CTRL_CMD_HI  = 4'h9;
  localparam logic [3:0] CTRL_CMD_LO  = 4'h2;
  localparam logic [3:0] CTRL_DATA_HI = 4'h1;
  localparam logic [3:0] CTRL_DATA_LO = 4'h3;

  // One control word of the microprogram
  typedef struct packed {
    logic [2:0]      emit;
    logic [1:0]      gate;
    logic            wr_frame_sp;
    logic            wr_shown_sp;
    logic            wr_shown_cell;
    logic            wr_put;
    logic            adv;
    logic            ic_inc;
    logic            need_upd;
    logic [2:0]      cond;
    logic [PC_W-1:0] jt;
    logic [PC_W-1:0] jf;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic stall;
    logic ic_last;
    logic last_cell;
    logic row_end;
    logic row_one;
  } seq_stat_t;

  // HD44780 start-up command list
  function automatic logic [7:0] init_cmd(input logic [IC_W-1:0] ic);
    logic [7:0] b;
    case (ic)
      3'd0, 3'd1, 3'd2: b = 8'h38;
      3'd3:             b = 8'h0C;
      3'd4:             b = 8'h01;
      3'd5:             b = 8'h06;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

  // First step of each operation's routine
  function automatic logic [PC_W-1:0] entry_step(input logic [2:0] op);
    logic [PC_W-1:0] s;
    case (op)
      OP_INIT:       s = P_INIT;
      OP_CLEAR:      s = P_FILL_FRAME;
      OP_PUT_CHAR:   s = P_PUT;
      OP_FLUSH:      s = P_FC_ADDR;
      OP_FLUSH_FULL: s = P_FF_ADDR;
      default:       s = P_DONE;
    endcase
    return s;
  endfunction

endpackage

### rtl/char_lcd_shadow_refresh_core.sv
// Top level of the character LCD frame buffer and refresh engine.
// Depends on lcdsr_pkg, lcdsr_ucode_rom, lcdsr_sequencer, lcdsr_cell_store
// and the assertion macro header.
//
// Usage:
//   Input channel (in_*): one beat per operation (init, clear, put char,
//   flush changed, flush full). Result channel (out_*): LCD bus beats, each
//   with its byte and both enable-strobe control values, then one done beat
//   with last set and error for a put char out of range.
//   Config channel (cfg_*): always ready; writes the backlight bit, which is
//   folded into the control values of later bus beats. Write it only when idle.
// Timing: a microprogram handles one item at a time; in_ready is high only
//   at the idle step.
// Stalls: each emitting step waits until the output register is free, so a
//   stalled receiver freezes the program; the done beat may still sit in the
//   output register while the next item is accepted.
// Reset: both buffers read as zero, backlight on, program at idle.
`include "char_lcd_shadow_refresh_core_macros.svh"

module char_lcd_shadow_refresh_core import lcdsr_pkg::*; #(
  parameter int COLS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [1:0] in_row,
  input  logic [5:0] in_column,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_bus_byte,
  output logic [3:0] out_ctrl_enable_high,
  output logic [3:0] out_ctrl_enable_low,
  output logic       out_error,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_backlight_on
);

  localparam int NCELLS = ROWS * COLS;
  localparam int IDX_W  = $clog2(NCELLS);

  logic [PC_W-1:0]  pc;
  uword_t           uword;
  seq_stat_t        stat;

  logic             in_fire;
  logic [1:0]       row_in_r;
  logic [COL_W-1:0] col_in_r;
  logic [7:0]       char_r;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_r, row_nxt;
  logic [IC_W-1:0]  ic_r, ic_nxt;
  logic             need_r, need_nxt;
  logic             err_r, err_nxt;
  logic             bl_r;

  logic [7:0]       frame_q, shown_q;
  logic             diff, gate_ok, emit_req, slot_free, stall, fire_emit, step_go;
  logic             row_end, last_cell, put_ok;
  logic [IDX_W-1:0] put_addr;

  logic             frame_we, shown_we;
  logic [IDX_W-1:0] frame_waddr;
  logic [7:0]       frame_wdata, shown_wdata;

  logic             out_valid_r;
  logic [1:0]       kind_r;
  logic [7:0]       byte_r;
  logic [3:0]       hi_r, lo_r;
  logic             oerr_r, last_r;
  logic [1:0]       kind_nxt;
  logic [7:0]       byte_nxt;
  logic [3:0]       hi_nxt, lo_nxt;

  // Control path
  lcdsr_ucode_rom u_rom (
    .pc    (pc),
    .uword (uword)
  );

  lcdsr_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .uword (uword),
    .stat  (stat),
    .op    (in_operation),
    .pc    (pc)
  );

  lcdsr_cell_store #(
    .NCELLS (NCELLS),
    .IDX_W  (IDX_W)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_addr     (idx_nxt),
    .frame_we    (frame_we),
    .frame_waddr (frame_waddr),
    .frame_wdata (frame_wdata),
    .shown_we    (shown_we),
    .shown_waddr (idx_r),
    .shown_wdata (shown_wdata),
    .frame_q     (frame_q),
    .shown_q     (shown_q)
  );

  assign in_ready  = (pc == P_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Emit gating and stall against the output register
  assign diff = (frame_q != shown_q);

  always_comb begin
    case (uword.gate)
      G_ALWAYS:    gate_ok = 1'b1;
      G_DIFF_NEED: gate_ok = diff && need_r;
      G_DIFF:      gate_ok = diff;
      default:     gate_ok = 1'b0;
    endcase
  end

  assign emit_req  = (uword.emit != E_NONE) && gate_ok;
  assign slot_free = !out_valid_r || out_ready;
  assign stall     = emit_req && !slot_free;
  assign fire_emit = emit_req && slot_free;
  assign step_go   = !stall;

  assign row_end   = (col_r == COL_W'(COLS - 1));
  assign last_cell = (idx_r == IDX_W'(NCELLS - 1));

  assign stat = '{in_fire: in_fire, stall: stall, ic_last: (ic_r == IC_W'(INIT_LEN - 1)),
                  last_cell: last_cell, row_end: row_end, row_one: row_r};

  // Advance the cell walk and the start-up counter
  always_comb begin
    idx_nxt  = idx_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    ic_nxt   = ic_r;
    need_nxt = need_r;
    err_nxt  = err_r;
    if (in_fire) begin
      idx_nxt  = '0;
      col_nxt  = '0;
      row_nxt  = 1'b0;
      ic_nxt   = '0;
      need_nxt = 1'b1;
      err_nxt  = 1'b0;
    end else if (step_go) begin
      if (uword.adv) begin
        idx_nxt = last_cell ? '0 : idx_r + 1'b1;
        col_nxt = row_end ? '0 : col_r + 1'b1;
        row_nxt = row_end ? ~row_r : row_r;
      end
      if (uword.ic_inc) begin
        ic_nxt = ic_r + 1'b1;
      end
      if (uword.need_upd) begin
        need_nxt = row_end || !diff;
      end else if (fire_emit && (uword.emit == E_ADDR)) begin
        need_nxt = 1'b0;
      end
      if (uword.wr_put && !put_ok) begin
        err_nxt = 1'b1;
      end
    end
  end

  // Hold the item fields, counters and backlight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_in_r <= in_row;
      col_in_r <= in_column;
      char_r   <= in_char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      col_r  <= '0;
      row_r  <= 1'b0;
      ic_r   <= '0;
      need_r <= 1'b1;
      err_r  <= 1'b0;
      bl_r   <= 1'b1;
    end else begin
      idx_r  <= idx_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ic_r   <= ic_nxt;
      need_r <= need_nxt;
      err_r  <= err_nxt;
      if (cfg_valid && cfg_ready) begin
        bl_r <= cfg_backlight_on;
      end
    end
  end

  // Memory writes: fills, character store and shadow update
  assign put_ok   = (row_in_r < 2'(ROWS)) && (col_in_r < COL_W'(COLS));
  assign put_addr = row_in_r[0] ? IDX_W'(COLS) + IDX_W'(col_in_r) : IDX_W'(col_in_r);

  assign frame_we    = step_go && (uword.wr_frame_sp || (uword.wr_put && put_ok));
  assign frame_waddr = uword.wr_put ? put_addr : idx_r;
  assign frame_wdata = uword.wr_put ? char_r : CHAR_SPACE;
  assign shown_we    = step_go && (uword.wr_shown_sp || (uword.wr_shown_cell && fire_emit));
  assign shown_wdata = uword.wr_shown_sp ? CHAR_SPACE : frame_q;

  // Build the next result beat
  always_comb begin
    case (uword.emit)
      E_INIT: begin
        kind_nxt = KIND_CMD;
        byte_nxt = init_cmd(ic_r);
      end
      E_ADDR: begin
        kind_nxt = KIND_CMD;
        byte_nxt = (row_r ? DDRAM_ROW1 : DDRAM_ROW0) + 8'(col_r);
      end
      E_DATA: begin
        kind_nxt = KIND_DATA;
        byte_nxt = frame_q;
      end
      default: begin
        kind_nxt = KIND_DONE;
        byte_nxt = 8'h00;
      end
    endcase
    case (kind_nxt)
      KIND_CMD: begin
        hi_nxt = CTRL_CMD_HI ^ {3'b000, bl_r};
        lo_nxt = CTRL_CMD_LO ^ {3'b000, bl_r};
      end
      KIND_DATA: begin
        hi_nxt = CTRL_DATA_HI ^ {3'b000, bl_r};
        lo_nxt = CTRL_DATA_LO ^ {3'b000, bl_r};
      end
      default: begin
        hi_nxt = 4'h0;
        lo_nxt = 4'h0;
      end
    endcase
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_emit) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      oerr_r <= (uword.emit == E_DONE) && err_r;
      last_r <= (uword.emit == E_DONE);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_bus_byte         = byte_r;
  assign out_ctrl_enable_high = hi_r;
  assign out_ctrl_enable_low  = lo_r;
  assign out_error            = oerr_r;
  assign out_last             = last_r;

  // Checks
  `LCDSR_ASSERT_NXT(a_fire_leaves_idle, in_fire, pc != P_IDLE, "accepted item did not start")
  `LCDSR_ASSERT_NXT(a_stall_holds_step, stall, pc == $past(pc), "step moved during stall")
  `LCDSR_ASSERT_IMP(a_last_is_done, out_valid && out_last, out_kind == KIND_DONE,
                    "last beat is not a done marker")
  `LCDSR_ASSERT_IMP(a_error_on_last, out_valid && out_error, out_last,
                    "error flag outside done marker")

endmodule

### rtl/lcdsr_ucode_rom.sv
// Microprogram table: one control word per step.
// Depends on lcdsr_pkg for the control word type and step codes.
module lcdsr_ucode_rom import lcdsr_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output uword_t          uword
);

  // Look up the control word of the current step
  always_comb begin
    case (pc)
      P_IDLE:
        uword = '{cond: C_DISPATCH, jt: P_IDLE, jf: P_IDLE, default: '0};
      P_INIT:
        uword = '{emit: E_INIT, gate: G_ALWAYS, ic_inc: 1'b1, cond: C_IC_LAST,
                  jt: P_FILL_ALL, jf: P_INIT, default: '0};
      P_FILL_ALL:
        uword = '{wr_frame_sp: 1'b1, wr_shown_sp: 1'b1, adv: 1'b1,
                  cond: C_LAST_CELL, jt: P_DONE, jf: P_FILL_ALL, default: '0};
      P_FILL_FRAME:
        uword = '{wr_frame_sp: 1'b1, adv: 1'b1, cond: C_LAST_CELL,
                  jt: P_DONE, jf: P_FILL_FRAME, default: '0};
      P_PUT:
        uword = '{wr_put: 1'b1, cond: C_ALWAYS, jt: P_DONE, jf: P_DONE,
                  default: '0};
      P_FC_ADDR:
        uword = '{emit: E_ADDR, gate: G_DIFF_NEED, cond: C_ALWAYS,
                  jt: P_FC_DATA, jf: P_FC_DATA, default: '0};
      P_FC_DATA:
        uword = '{emit: E_DATA, gate: G_DIFF, wr_shown_cell: 1'b1, adv: 1'b1,
                  need_upd: 1'b1, cond: C_LAST_CELL, jt: P_DONE, jf: P_FC_ADDR,
                  default: '0};
      P_FF_ADDR:
        uword = '{emit: E_ADDR, gate: G_ALWAYS, cond: C_ALWAYS,
                  jt: P_FF_DATA, jf: P_FF_DATA, default: '0};
      P_FF_DATA:
        uword = '{emit: E_DATA, gate: G_ALWAYS, wr_shown_cell: 1'b1, adv: 1'b1,
                  cond: C_ROW_END, jt: P_FF_ROW, jf: P_FF_DATA, default: '0};
      P_FF_ROW:
        uword = '{cond: C_ROW_ONE, jt: P_FF_ADDR, jf: P_DONE, default: '0};
      P_DONE:
        uword = '{emit: E_DONE, gate: G_ALWAYS, cond: C_ALWAYS,
                  jt: P_IDLE, jf: P_IDLE, default: '0};
      default:
        uword = '{cond: C_ALWAYS, jt: P_IDLE, jf: P_IDLE, default: '0};
    endcase
  end

endmodule

### rtl/lcdsr_sequencer.sv
// Step counter with conditional jumps and operation dispatch.
// Depends on lcdsr_pkg for control word, status type and step codes.
module lcdsr_sequencer import lcdsr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  uword_t          uword,
  input  seq_stat_t       stat,
  input  logic [2:0]      op,
  output logic [PC_W-1:0] pc
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  // Evaluate the jump condition
  always_comb begin
    case (uword.cond)
      C_ALWAYS:    take = 1'b1;
      C_DISPATCH:  take = stat.in_fire;
      C_IC_LAST:   take = stat.ic_last;
      C_LAST_CELL: take = stat.last_cell;
      C_ROW_END:   take = stat.row_end;
      C_ROW_ONE:   take = stat.row_one;
      default:     take = 1'b0;
    endcase
  end

  // Hold on a stalled emit, dispatch from idle, otherwise branch
  always_comb begin
    if (stat.stall) begin
      pc_nxt = pc_r;
    end else if (uword.cond == C_DISPATCH) begin
      pc_nxt = take ? entry_step(op) : P_IDLE;
    end else begin
      pc_nxt = take ? uword.jt : uword.jf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign pc = pc_r;

endmodule

### rtl/lcdsr_cell_store.sv
// Frame buffer and shown-copy memories, one write and one read port each.
// Depends on lcdsr_pkg; entries never written read back as zero.
module lcdsr_cell_store import lcdsr_pkg::*; #(
  parameter int NCELLS = 40,
  parameter int IDX_W  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             frame_we,
  input  logic [IDX_W-1:0] frame_waddr,
  input  logic [7:0]       frame_wdata,
  input  logic             shown_we,
  input  logic [IDX_W-1:0] shown_waddr,
  input  logic [7:0]       shown_wdata,
  output logic [7:0]       frame_q,
  output logic [7:0]       shown_q
);

  logic [7:0]        frame_mem [NCELLS];
  logic [7:0]        shown_mem [NCELLS];
  logic [NCELLS-1:0] frame_vld_r;
  logic [NCELLS-1:0] shown_vld_r;
  logic [7:0]        frame_rd_r;
  logic [7:0]        shown_rd_r;
  logic              frame_vq_r;
  logic              shown_vq_r;

  // Write and read the memories
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= frame_wdata;
    end
    if (shown_we) begin
      shown_mem[shown_waddr] <= shown_wdata;
    end
    frame_rd_r <= frame_mem[rd_addr];
    shown_rd_r <= shown_mem[rd_addr];
  end

  // Track written entries so unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= '0;
      shown_vld_r <= '0;
      frame_vq_r  <= 1'b0;
      shown_vq_r  <= 1'b0;
    end else begin
      if (frame_we) begin
        frame_vld_r[frame_waddr] <= 1'b1;
      end
      if (shown_we) begin
        shown_vld_r[shown_waddr] <= 1'b1;
      end
      frame_vq_r <= frame_vld_r[rd_addr];
      shown_vq_r <= shown_vld_r[rd_addr];
    end
  end

  assign frame_q = frame_vq_r ? frame_rd_r : 8'h00;
  assign shown_q = shown_vq_r ? shown_rd_r : 8'h00;

endmodule
